FILE: src/stabilizer_tableau_gate_engine_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the tableau engine checker
// ----------------------------------------------------------------------------
`ifndef STABILIZER_TABLEAU_GATE_ENGINE_TOP_MACROS_SVH
`define STABILIZER_TABLEAU_GATE_ENGINE_TOP_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define STG_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define STG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/stg_pkg.sv
// ----------------------------------------------------------------------------
// stg_pkg
// Shared types and codes of the tableau gate engine.
// ----------------------------------------------------------------------------
`default_nettype none
package stg_pkg;
   localparam int OpWidth = 4;

   typedef enum logic [OpWidth-1:0] {
      OP_H      = 4'd0,
      OP_S      = 4'd1,
      OP_CX     = 4'd2,
      OP_CZ     = 4'd3,
      OP_X      = 4'd4,
      OP_ROWSUM = 4'd5,
      OP_SWAP   = 4'd6,
      OP_READ   = 4'd7,
      OP_REINIT = 4'd8
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_GATE,
      ST_SUMRD,
      ST_SUM,
      ST_SWAP,
      ST_RDOUT,
      ST_RESP
   } state_type;

   // which gate pass the row unit applies
   typedef enum logic [1:0] {
      G_H,
      G_S,
      G_CX
   } gate_type;

   localparam int CsrQubits = 0;
   localparam int CsrRows   = 1;
   localparam int CfgWidth  = 6;

   // g of CHP modulo 4: (x1,z1) from source row, (x2,z2) from target row
   function automatic logic [1:0] g_mod4(input logic x1, input logic z1,
                                         input logic x2, input logic z2);
      logic [1:0] g;
      g = 2'd0;
      if (x1 && !z1) g = z2 ? (x2 ? 2'd1 : 2'd3) : 2'd0;
      else if (!x1 && z1) g = x2 ? (z2 ? 2'd3 : 2'd1) : 2'd0;
      else if (x1 && z1) begin
         if (z2 && !x2) g = 2'd1;
         else if (x2 && !z2) g = 2'd3;
      end
      return g;
   endfunction
endpackage
`default_nettype wire

FILE: src/stabilizer_tableau_gate_engine_top.sv
// ----------------------------------------------------------------------------
// stabilizer_tableau_gate_engine_top
// Stabilizer tableau held in RAM; gates sweep the rows through one row unit.
// ----------------------------------------------------------------------------
// Usage: pulse req_start with req_opcode/req_operand_a/req_operand_b while
// req_busy is low; the command is taken on that edge and busy rises. When
// done, rsp_valid is high for one cycle with rsp_status and row operand_a.
// Configuration (active qubits, active rows) goes over the APB port.
// Passes: each row of a pass is read from RAM and written back through the
// shared row unit in the following cycle. H, S and CX take one pass, CZ
// three and X four. Rowsum puts the phase sum through the g unit one active
// qubit column per cycle. Reinit makes one write per row.
// Busy drops in the strobe cycle, so the next command can be taken there.
// After reset a clearing pass writes all MAX_ROWS rows of the reset tableau;
// busy stays high during it. The receiver cannot stall; results are never
// held back.
`default_nettype none
module stabilizer_tableau_gate_engine_top #(
   parameter int MAX_QUBITS = 32,
   parameter int MAX_ROWS   = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_start,
   output      logic        req_busy,
   input  wire logic [3:0]  req_opcode,
   input  wire logic [4:0]  req_operand_a,
   input  wire logic [4:0]  req_operand_b,
   output      logic        rsp_valid,
   output      logic        rsp_status,
   output      logic [31:0] rsp_row_x,
   output      logic [31:0] rsp_row_z,
   output      logic        rsp_row_sign,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output      logic [31:0] prdata,
   output      logic        pready
);
   import stg_pkg::*;

   localparam int QW  = MAX_QUBITS;
   localparam int QB  = $clog2(MAX_QUBITS);
   localparam int RB  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int RD  = 1 << RB;
   localparam int RW  = 2 * QW + 1;
   localparam int CB  = QB + 1;

   // ---------------- configuration ----------------
   logic [CfgWidth-1:0] qubits_ff, rows_ff;
   logic                wr_csr;
   logic [6:0]          n_eff, k_eff;

   assign pready = 1'b1;
   assign wr_csr = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         qubits_ff <= CfgWidth'(32);
         rows_ff   <= CfgWidth'(32);
      end else if (wr_csr) begin
         if (paddr[2] == 1'(CsrQubits)) qubits_ff <= pwdata[CfgWidth-1:0];
         else rows_ff <= pwdata[CfgWidth-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == 1'(CsrQubits)) prdata[CfgWidth-1:0] = qubits_ff;
      else prdata[CfgWidth-1:0] = rows_ff;
   end

   assign n_eff = (7'(qubits_ff) < 7'(MAX_QUBITS)) ? 7'(qubits_ff) : 7'(MAX_QUBITS);
   assign k_eff = (7'(rows_ff) < 7'(MAX_ROWS)) ? 7'(rows_ff) : 7'(MAX_ROWS);

   // ---------------- command registers ----------------
   state_type         state_ff, state_in;
   op_type            op_ff, op_in;
   logic [4:0]        a_ff, a_in, b_ff, b_in;
   logic              status_ff, status_in;
   logic [RB:0]       row_ff, row_in;      // sweep row counter
   logic              phase_ff, phase_in;  // 0 read, 1 write within a pass
   logic [1:0]        pass_ff, pass_in;
   logic [CB-1:0]     col_ff, col_in;
   logic [1:0]        sum_ff, sum_in;
   logic [RW-1:0]     tgt_ff, tgt_in;      // held target row (rowsum/swap)
   logic              valid_ff, valid_in;

   // RAM
   logic              wr_en;
   logic [RB-1:0]     wr_addr, rd_addr;
   logic [RW-1:0]     wr_data, rd_data;

   stg_ram #(.WIDTH(RW), .DEPTH(RD)) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // row unit
   gate_type      gsel;
   logic [QB-1:0] gqa, gqb;
   logic [QW-1:0] ux, uz;
   logic          us;

   stg_row_unit #(.QW(QW)) u_unit (
      .gate(gsel),
      .qa  (gqa),
      .qb  (gqb),
      .x_i (rd_data[RW-1:QW+1]),
      .z_i (rd_data[QW:1]),
      .s_i (rd_data[0]),
      .x_o (ux),
      .z_o (uz),
      .s_o (us)
   );

   // gate sequence per pass for composite ops
   always_comb begin
      gsel = G_H;
      gqa  = QB'(a_ff);
      gqb  = QB'(b_ff);
      case (op_ff)
         OP_S:  gsel = G_S;
         OP_CX: gsel = G_CX;
         OP_CZ: begin
            gsel = (pass_ff == 2'd1) ? G_CX : G_H;
            if (pass_ff != 2'd1) gqa = QB'(b_ff);
         end
         OP_X:  gsel = (pass_ff == 2'd1 || pass_ff == 2'd2) ? G_S : G_H;
         default: gsel = G_H;
      endcase
   end

   logic [QW-1:0] tx, tz, sx, sz, qmask;
   logic          a_bad_q, b_bad_q, a_bad_r, b_bad_r;
   logic [1:0]    last_pass;
   logic [RB-1:0] rinit;

   assign tx = tgt_ff[RW-1:QW+1];
   assign tz = tgt_ff[QW:1];
   assign sx = rd_data[RW-1:QW+1];
   assign sz = rd_data[QW:1];
   assign a_bad_q = 7'(req_operand_a) >= n_eff;
   assign b_bad_q = 7'(req_operand_b) >= n_eff;
   assign a_bad_r = 7'(req_operand_a) >= k_eff;
   assign b_bad_r = 7'(req_operand_b) >= k_eff;
   assign rinit   = row_ff[RB-1:0];

   always_comb begin
      for (int q = 0; q < QW; q++) qmask[q] = 7'(q) < n_eff;
      case (op_ff)
         OP_CZ:   last_pass = 2'd2;
         OP_X:    last_pass = 2'd3;
         default: last_pass = 2'd0;
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      status_in = status_ff;
      row_in    = row_ff;
      phase_in  = phase_ff;
      pass_in   = pass_ff;
      col_in    = col_ff;
      sum_in    = sum_ff;
      tgt_in    = tgt_ff;
      valid_in  = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = row_ff[RB-1:0];
      wr_data   = '0;
      rd_addr   = row_ff[RB-1:0];
      case (state_ff)
         ST_CLEAR: begin
            wr_en = 1'b1;
            wr_data = '0;
            for (int q = 0; q < QW; q++)
               if (q < RD && RB'(q) == rinit) wr_data[1+q] = 1'b1;
            row_in = row_ff + 1'b1;
            if (row_ff == (RB+1)'(MAX_ROWS - 1)) begin
               state_in = (op_ff == OP_REINIT) ? ST_RDOUT : ST_IDLE;
               row_in = '0;
            end
         end
         ST_IDLE: begin
            if (req_start) begin
               op_in     = op_type'(req_opcode);
               a_in      = req_operand_a;
               b_in      = req_operand_b;
               row_in    = '0;
               phase_in  = 1'b0;
               pass_in   = 2'd0;
               col_in    = '0;
               status_in = 1'b0;
               state_in  = ST_RDOUT;
               case (op_type'(req_opcode))
                  OP_H, OP_S, OP_X: begin
                     if (a_bad_q) status_in = 1'b1;
                     else state_in = ST_GATE;
                  end
                  OP_CX, OP_CZ: begin
                     if (a_bad_q || b_bad_q || req_operand_a == req_operand_b)
                        status_in = 1'b1;
                     else state_in = ST_GATE;
                  end
                  OP_ROWSUM: begin
                     if (a_bad_r || b_bad_r) status_in = 1'b1;
                     else state_in = ST_SUMRD;
                  end
                  OP_SWAP: begin
                     if (a_bad_r || b_bad_r) status_in = 1'b1;
                     else if (req_operand_a != req_operand_b) state_in = ST_SUMRD;
                  end
                  OP_READ: if (a_bad_r) status_in = 1'b1;
                  OP_REINIT: state_in = ST_CLEAR;
                  default: status_in = 1'b1;
               endcase
            end
         end
         ST_GATE: begin
            // read row, then write it back through the unit
            if (row_ff >= (RB+1)'(k_eff)) begin
               row_in = '0;
               phase_in = 1'b0;
               if (pass_ff == last_pass) state_in = ST_RDOUT;
               else pass_in = pass_ff + 2'd1;
            end else if (!phase_ff) begin
               phase_in = 1'b1;
            end else begin
               wr_en    = 1'b1;
               wr_data  = {ux, uz, us};
               phase_in = 1'b0;
               row_in   = row_ff + 1'b1;
            end
         end
         ST_SUMRD: begin
            // fetch row a into the holding register, then row b
            rd_addr = phase_ff ? RB'(b_ff) : RB'(a_ff);
            if (!phase_ff) phase_in = 1'b1;
            else begin
               tgt_in   = rd_data;
               phase_in = 1'b0;
               sum_in   = {rd_data[0], 1'b0};
               col_in   = '0;
               state_in = (op_ff == OP_SWAP) ? ST_SWAP : ST_SUM;
            end
         end
         ST_SUM: begin
            // rd_data holds row b (read address held at b)
            rd_addr = RB'(b_ff);
            if (!phase_ff) begin
               phase_in = 1'b1;
               sum_in   = sum_ff + {rd_data[0], 1'b0};
            end else if (7'(col_ff) < n_eff && col_ff < CB'(QW)) begin
               sum_in = sum_ff + g_mod4(sx[col_ff[QB-1:0]], sz[col_ff[QB-1:0]],
                                        tx[col_ff[QB-1:0]], tz[col_ff[QB-1:0]]);
               col_in = col_ff + 1'b1;
            end else begin
               wr_en   = 1'b1;
               wr_addr = RB'(a_ff);
               wr_data = {tx ^ (sx & qmask), tz ^ (sz & qmask),
                          (sum_ff == 2'd0) ? 1'b0 :
                          (sum_ff == 2'd2) ? 1'b1 : tgt_ff[0]};
               phase_in = 1'b0;
               state_in = ST_RDOUT;
            end
         end
         ST_SWAP: begin
            rd_addr = RB'(b_ff);
            wr_en   = 1'b1;
            if (!phase_ff) begin
               wr_addr  = RB'(b_ff);
               wr_data  = tgt_ff;
               phase_in = 1'b1;
               tgt_in   = rd_data;
            end else begin
               wr_addr  = RB'(a_ff);
               wr_data  = tgt_ff;
               phase_in = 1'b0;
               state_in = ST_RDOUT;
            end
         end
         ST_RDOUT: begin
            rd_addr  = RB'(a_ff);
            state_in = ST_RESP;
         end
         ST_RESP: begin
            rd_addr  = RB'(a_ff);
            valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         op_ff    <= OP_H;
         row_ff   <= '0;
         phase_ff <= 1'b0;
         pass_ff  <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         row_ff   <= row_in;
         phase_ff <= phase_in;
         pass_ff  <= pass_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff      <= a_in;
      b_ff      <= b_in;
      status_ff <= status_in;
      col_ff    <= col_in;
      sum_ff    <= sum_in;
      tgt_ff    <= tgt_in;
   end

   // response register
   logic [31:0] ox_ff, oz_ff;
   logic        os_ff, ost_ff;
   logic [QW-1:0] rx, rz;
   logic        in_rows;

   assign rx = rd_data[RW-1:QW+1];
   assign rz = rd_data[QW:1];
   assign in_rows = 7'(a_ff) < k_eff;

   always_ff @(posedge clock) begin
      if (valid_in) begin
         ost_ff <= status_ff;
         for (int q = 0; q < 32; q++) begin
            ox_ff[q] <= (q < QW) ? (in_rows & rx[q % QW]) : 1'b0;
            oz_ff[q] <= (q < QW) ? (in_rows & rz[q % QW]) : 1'b0;
         end
         os_ff <= in_rows & rd_data[0];
      end
   end

   assign req_busy     = state_ff != ST_IDLE;
   assign rsp_valid    = valid_ff;
   assign rsp_status   = ost_ff;
   assign rsp_row_x    = ox_ff;
   assign rsp_row_z    = oz_ff;
   assign rsp_row_sign = os_ff;
endmodule
`default_nettype wire

FILE: src/stg_ram.sv
// ----------------------------------------------------------------------------
// stg_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module stg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

FILE: src/stg_row_unit.sv
// ----------------------------------------------------------------------------
// stg_row_unit
// Shared row datapath: one gate step on one row (H, S or CX on columns a,b).
// ----------------------------------------------------------------------------
`default_nettype none
module stg_row_unit #(
   parameter int QW = 32
) (
   input  wire stg_pkg::gate_type     gate,
   input  wire logic [$clog2(QW)-1:0] qa,
   input  wire logic [$clog2(QW)-1:0] qb,
   input  wire logic [QW-1:0]         x_i,
   input  wire logic [QW-1:0]         z_i,
   input  wire logic                  s_i,
   output      logic [QW-1:0]         x_o,
   output      logic [QW-1:0]         z_o,
   output      logic                  s_o
);
   import stg_pkg::*;
   logic xa, za, xb, zb;

   always_comb begin
      xa  = x_i[qa];
      za  = z_i[qa];
      xb  = x_i[qb];
      zb  = z_i[qb];
      x_o = x_i;
      z_o = z_i;
      s_o = s_i;
      case (gate)
         G_H: begin
            s_o     = s_i ^ (xa & za);
            x_o[qa] = za;
            z_o[qa] = xa;
         end
         G_S: begin
            s_o     = s_i ^ (xa & za);
            z_o[qa] = za ^ xa;
         end
         G_CX: begin
            s_o     = s_i ^ (xa & zb & ~(xb ^ za));
            x_o[qb] = xb ^ xa;
            z_o[qa] = za ^ zb;
         end
         default: ;
      endcase
   end
endmodule
`default_nettype wire

FILE: src/stg_checker.sv
// ----------------------------------------------------------------------------
// stg_checker
// Port-level checks of the tableau engine command and result timing.
// ----------------------------------------------------------------------------
`default_nettype none
`include "stabilizer_tableau_gate_engine_top_macros.svh"
module stg_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_start,
   input wire logic req_busy,
   input wire logic rsp_valid,
   input wire logic pready
);
   // a result only ends a command: busy was high the cycle before
   `STG_ASSERT_IMP(a_rsp_after_busy, clock, reset, rsp_valid, $past(req_busy), "result without command")
   // one cycle strobe
   `STG_ASSERT_NEXT(a_rsp_pulse, clock, reset, rsp_valid, !rsp_valid, "result strobe too long")
   // accepted command makes the block busy
   `STG_ASSERT_NEXT(a_busy_on_start, clock, reset, req_start && !req_busy, req_busy, "no busy after start")
   `STG_ASSERT_IMP(a_pready, clock, reset, 1'b1, pready, "pready low")
endmodule
bind stabilizer_tableau_gate_engine_top stg_checker u_stg_checker (
   .clock    (clock),
   .reset    (reset),
   .req_start(req_start),
   .req_busy (req_busy),
   .rsp_valid(rsp_valid),
   .pready   (pready)
);
`default_nettype wire

FILE: tb/stabilizer_tableau_gate_engine_checker.sv
// ----------------------------------------------------------------------------
// stabilizer_tableau_gate_engine_checker
// Watches command and response transfers and the CSR port, keeps its own
// copy of the tableau, and compares every response with the predicted one.
// ----------------------------------------------------------------------------
module stabilizer_tableau_gate_engine_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_start,
   input  logic        req_busy,
   input  logic [3:0]  req_opcode,
   input  logic [4:0]  req_operand_a,
   input  logic [4:0]  req_operand_b,
   input  logic        rsp_valid,
   input  logic        rsp_status,
   input  logic [31:0] rsp_row_x,
   input  logic [31:0] rsp_row_z,
   input  logic        rsp_row_sign,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   input  logic        pready,
   output int          fail_count,
   output int          pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import stg_pkg::*;

   typedef struct packed {
      logic        status;
      logic [31:0] row_x;
      logic [31:0] row_z;
      logic        sign;
   } row_report_type;

   logic [31:0] tab_x [32];
   logic [31:0] tab_z [32];
   logic        tab_sign [32];
   logic [5:0]  qubits_cfg, rows_cfg;
   row_report_type expected_reports [$];

   assign pending_count = expected_reports.size();

   function automatic int eff_qubits();
      return (qubits_cfg > 32) ? 32 : int'(qubits_cfg);
   endfunction

   function automatic int eff_rows();
      return (rows_cfg > 32) ? 32 : int'(rows_cfg);
   endfunction

   function automatic void load_initial_tableau();
      for (int r = 0; r < 32; r++) begin
         tab_x[r] = '0;
         tab_z[r] = 32'd1 << r;
         tab_sign[r] = 1'b0;
      end
   endfunction

   function automatic void apply_h(int q);
      logic xa, za;
      for (int r = 0; r < eff_rows(); r++) begin
         xa = tab_x[r][q];
         za = tab_z[r][q];
         tab_sign[r] ^= xa & za;
         tab_x[r][q] = za;
         tab_z[r][q] = xa;
      end
   endfunction

   function automatic void apply_s(int q);
      for (int r = 0; r < eff_rows(); r++) begin
         tab_sign[r] ^= tab_x[r][q] & tab_z[r][q];
         tab_z[r][q] ^= tab_x[r][q];
      end
   endfunction

   function automatic void apply_cx(int a, int b);
      logic xa, za, xb, zb;
      for (int r = 0; r < eff_rows(); r++) begin
         xa = tab_x[r][a]; za = tab_z[r][a];
         xb = tab_x[r][b]; zb = tab_z[r][b];
         tab_sign[r] ^= xa & zb & ~(xb ^ za);
         tab_x[r][b] ^= xa;
         tab_z[r][a] ^= zb;
      end
   endfunction

   // Pauli product phase exponent, source (x1,z1) times target (x2,z2)
   function automatic logic [1:0] pauli_phase(logic x1, logic z1, logic x2, logic z2);
      if (x1 && !z1) return z2 ? (x2 ? 2'd1 : 2'd3) : 2'd0;
      if (!x1 && z1) return x2 ? (z2 ? 2'd3 : 2'd1) : 2'd0;
      if (x1 && z1) begin
         if (z2 && !x2) return 2'd1;
         if (x2 && !z2) return 2'd3;
      end
      return 2'd0;
   endfunction

   function automatic void multiply_rows(int h, int i);
      logic [1:0]  acc;
      logic [31:0] m;
      acc = {tab_sign[h] ^ tab_sign[i], 1'b0};
      m = '0;
      for (int j = 0; j < eff_qubits(); j++) begin
         acc += pauli_phase(tab_x[i][j], tab_z[i][j], tab_x[h][j], tab_z[h][j]);
         m[j] = 1'b1;
      end
      if (acc == 2'd0) tab_sign[h] = 1'b0;
      if (acc == 2'd2) tab_sign[h] = 1'b1;
      tab_x[h] ^= tab_x[i] & m;
      tab_z[h] ^= tab_z[i] & m;
   endfunction

   function automatic row_report_type execute_command(logic [3:0] op, int a, int b);
      row_report_type rep;
      logic [31:0] tx, tz;
      logic        ts;
      int          n, k;
      n = eff_qubits();
      k = eff_rows();
      rep = '0;
      case (op)
         OP_H, OP_S, OP_X: begin
            if (a >= n) rep.status = 1'b1;
            else if (op == OP_H) apply_h(a);
            else if (op == OP_S) apply_s(a);
            else begin
               apply_h(a); apply_s(a); apply_s(a); apply_h(a);
            end
         end
         OP_CX, OP_CZ: begin
            if (a >= n || b >= n || a == b) rep.status = 1'b1;
            else if (op == OP_CX) apply_cx(a, b);
            else begin
               apply_h(b); apply_cx(a, b); apply_h(b);
            end
         end
         OP_ROWSUM: begin
            if (a >= k || b >= k) rep.status = 1'b1;
            else multiply_rows(a, b);
         end
         OP_SWAP: begin
            if (a >= k || b >= k) rep.status = 1'b1;
            else begin
               tx = tab_x[a]; tz = tab_z[a]; ts = tab_sign[a];
               tab_x[a] = tab_x[b]; tab_z[a] = tab_z[b]; tab_sign[a] = tab_sign[b];
               tab_x[b] = tx; tab_z[b] = tz; tab_sign[b] = ts;
            end
         end
         OP_READ: rep.status = (a >= k);
         OP_REINIT: load_initial_tableau();
         default: rep.status = 1'b1;
      endcase
      if (a < k) begin
         rep.row_x = tab_x[a];
         rep.row_z = tab_z[a];
         rep.sign = tab_sign[a];
      end
      return rep;
   endfunction

   always @(posedge clock) begin
      row_report_type exp_rep;
      if (reset) begin
         load_initial_tableau();
         qubits_cfg <= 6'd32;
         rows_cfg <= 6'd32;
         expected_reports.delete();
         fail_count <= 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            if (paddr == 3'(4 * CsrQubits)) qubits_cfg <= pwdata[5:0];
            else if (paddr == 3'(4 * CsrRows)) rows_cfg <= pwdata[5:0];
         end
         if (req_start && !req_busy)
            expected_reports.push_back(execute_command(req_opcode,
               int'(req_operand_a), int'(req_operand_b)));
         if (rsp_valid) begin
            if (expected_reports.size() == 0) begin
               $display("%0t: unexpected response status=%0b x=%h z=%h sign=%0b", $realtime,
                  rsp_status, rsp_row_x, rsp_row_z, rsp_row_sign);
               fail_count <= fail_count + 1;
            end else begin
               exp_rep = expected_reports.pop_front();
               if (exp_rep.status !== rsp_status || exp_rep.row_x !== rsp_row_x ||
                   exp_rep.row_z !== rsp_row_z || exp_rep.sign !== rsp_row_sign) begin
                  $display("%0t: mismatch expected status=%0b x=%h z=%h sign=%0b", $realtime,
                     exp_rep.status, exp_rep.row_x, exp_rep.row_z, exp_rep.sign);
                  $display("%0t:          actual   status=%0b x=%h z=%h sign=%0b", $realtime,
                     rsp_status, rsp_row_x, rsp_row_z, rsp_row_sign);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

FILE: tb/stabilizer_tableau_gate_engine_top_tb.sv
// ----------------------------------------------------------------------------
// stabilizer_tableau_gate_engine_top_tb
// Drives gate, rowsum, swap, read and reinit commands with random gaps across
// several qubit/row settings; the checker predicts and compares responses.
// ----------------------------------------------------------------------------
module stabilizer_tableau_gate_engine_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import stg_pkg::*;

   localparam int CycleLimit = 3000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_start = 1'b0;
   logic        req_busy;
   logic [3:0]  req_opcode = '0;
   logic [4:0]  req_operand_a = '0;
   logic [4:0]  req_operand_b = '0;
   logic        rsp_valid, rsp_status, rsp_row_sign;
   logic [31:0] rsp_row_x, rsp_row_z;
   logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;
   int          fail_count, pending_count;
   int          cycle_count = 0;
   int          qubits_now = 32, rows_now = 32;

   always #10 clock = ~clock;

   stabilizer_tableau_gate_engine_top u_dut (.*);

   stabilizer_tableau_gate_engine_checker u_checker (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic csr_write(int index, logic [31:0] value);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= 3'(4 * index); pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
   endtask

   task automatic idle_cycles(int n);
      repeat (n) @(posedge clock);
   endtask

   task automatic send_command(logic [3:0] op, logic [4:0] a, logic [4:0] b);
      int gap;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
      if ($urandom_range(0, 3) == 0) gap = 0;
      idle_cycles(gap);
      req_start <= 1'b1;
      req_opcode <= op; req_operand_a <= a; req_operand_b <= b;
      @(posedge clock);
      while (req_busy) @(posedge clock);
      req_start <= 1'b0;
      // scramble fields while start is low
      req_opcode <= 4'($urandom); req_operand_a <= 5'($urandom);
      req_operand_b <= 5'($urandom);
      @(posedge clock);
   endtask

   task automatic drain_and_configure(int q, int r);
      while (pending_count != 0) @(posedge clock);
      idle_cycles(300);
      csr_write(CsrQubits, 32'(q));
      csr_write(CsrRows, 32'(r));
      qubits_now = q;
      rows_now = r;
   endtask

   // mostly in-range operands, sometimes anything
   function automatic logic [4:0] pick_operand(int limit);
      if (limit > 0 && $urandom_range(0, 7) != 0) return 5'($urandom_range(0, limit - 1));
      return 5'($urandom);
   endfunction

   task automatic random_commands(int count);
      logic [3:0] op;
      int lim;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 19))
            0:       op = OP_REINIT;
            1:       op = 4'($urandom_range(9, 15));
            2, 3, 4: op = OP_ROWSUM;
            5, 6:    op = OP_SWAP;
            7, 8:    op = OP_READ;
            default: op = 4'($urandom_range(0, 4));
         endcase
         lim = (op >= OP_ROWSUM) ? rows_now : qubits_now;
         if (op == OP_REINIT && $urandom_range(0, 1)) op = OP_H;
         send_command(op, pick_operand(lim), pick_operand(lim));
      end
   endtask

   initial begin
      idle_cycles(3);
      reset <= 1'b0;
      @(posedge clock);
      // directed
      send_command(OP_READ, 5'd0, 5'd0);
      send_command(OP_H, 5'd0, 5'd0);
      send_command(OP_S, 5'd31, 5'd0);
      send_command(OP_S, 5'd0, 5'd0);
      send_command(OP_H, 5'd0, 5'd0);
      send_command(OP_CX, 5'd0, 5'd31);
      send_command(OP_CX, 5'd3, 5'd3);
      send_command(OP_CZ, 5'd31, 5'd1);
      send_command(OP_CZ, 5'd2, 5'd2);
      send_command(OP_X, 5'd5, 5'd0);
      send_command(OP_ROWSUM, 5'd31, 5'd0);
      send_command(OP_ROWSUM, 5'd4, 5'd4);
      send_command(OP_SWAP, 5'd0, 5'd31);
      send_command(OP_SWAP, 5'd7, 5'd7);
      send_command(OP_READ, 5'd31, 5'd0);
      send_command(4'd9, 5'd1, 5'd2);
      send_command(4'd15, 5'd31, 5'd31);
      send_command(OP_REINIT, 5'd31, 5'd17);
      drain_and_configure(1, 0);
      send_command(OP_H, 5'd0, 5'd0);
      send_command(OP_H, 5'd1, 5'd0);
      send_command(OP_READ, 5'd0, 5'd0);
      send_command(OP_ROWSUM, 5'd0, 5'd0);
      drain_and_configure(63, 63);
      random_commands(300);
      drain_and_configure(5, 7);
      random_commands(400);
      drain_and_configure(32, 1);
      random_commands(150);
      drain_and_configure(2, 32);
      random_commands(250);
      drain_and_configure(20, 12);
      random_commands(300);
      drain_and_configure(32, 32);
      random_commands(300);
      while (pending_count != 0) @(posedge clock);
      idle_cycles(300);
      if (fail_count == 0 && pending_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
